// ===== rtl/core/seven_segment_sequence_player_defines.svh =====
// assertion helpers shared by the rtl that checks itself
`ifndef SEVEN_SEGMENT_SEQUENCE_PLAYER_DEFINES_SVH
`define SEVEN_SEGMENT_SEQUENCE_PLAYER_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define SSSP_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define SSSP_ASSERT_NEXT(label, trig, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error(msg);

`endif

// ===== rtl/core/sssp_pkg.sv =====
package sssp_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam logic [15:0] ON_TICKS_RESET  = 16'd200;
    localparam logic [15:0] OFF_TICKS_RESET = 16'd100;

    localparam logic [1:0] CFG_ON_TICKS  = 2'd0;
    localparam logic [1:0] CFG_OFF_TICKS = 2'd1;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_RESEND = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SENDING = 2'd1,
        PH_SHOWING = 2'd2,
        PH_WAITING = 2'd3
    } phase_t;

    localparam logic [7:0] CHAR_POINT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] GLYPH_COUNT = 8'd16;
    localparam logic [7:0] GLYPH_POINT = 8'd10;
    localparam logic [7:0] PATTERN_BLANK = 8'hFF;

    // active-low dp g f e d c b a
    localparam logic [7:0] GLYPH_TABLE [16] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
        8'h80, 8'h98, 8'h7F, 8'hBF, 8'h9C, 8'h06, 8'hB0, 8'hA3
    };

endpackage

// ===== rtl/core/sssp_ram.sv =====
module sssp_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(WORDS)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(WORDS)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/seven_segment_sequence_player.sv =====
// Plays a loaded character string on one active-low seven-segment digit. Each
// transaction on the input channel (load, tick or resend) yields exactly one
// result in the following cycle, held in a single output register; the block takes one
// transaction per clock, also while a result waits, as long as that result
// leaves in the same cycle. Characters sit in a two-bank store RAM (each bank
// 2**clog2(DEPTH) words, one write and one registered read per clock); the read
// address always follows the next sequencer position so the character to show is
// ready when the next tick arrives. Configuration writes are taken in any cycle.
`include "seven_segment_sequence_player_defines.svh"

module seven_segment_sequence_player #(
    parameter int DEPTH = sssp_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  char_in,
    input  logic        last_char,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        sent,
    output logic [7:0]  segments,
    output logic        spi_first,
    output logic [7:0]  spi_second,
    output logic        idle,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = IW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [15:0]          on_ticks_reg;
    logic [15:0]          off_ticks_reg;
    logic                 play_bank_reg, play_bank_next;
    logic [CW-1:0]        load_count_reg, load_count_next;
    logic [CW-1:0]        play_length_reg, play_length_next;
    logic [CW-1:0]        read_index_reg, read_index_next;
    sssp_pkg::phase_t     phase_reg, phase_next;
    logic [15:0]          timeout_reg, timeout_next;
    logic [3:0]           last_glyph_reg, last_glyph_next;

    logic                 byp_valid_reg;
    logic [7:0]           byp_data_reg;

    logic                 out_valid_reg, out_valid_next;
    logic                 sent_reg, sent_next;
    logic [7:0]           pattern_reg, pattern_next;
    logic                 idle_reg;

    logic                 in_accept;
    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [AW-1:0]        mem_rd_addr;
    logic [7:0]           mem_rd_data;
    logic [7:0]           char_cur;
    logic [7:0]           digit;
    logic                 glyph_hit;
    logic [7:0]           glyph_pattern;
    logic [CW-1:0]        load_count_inc;
    logic [15:0]          timeout_dec;
    logic                 index_in_range;

    assign in_accept = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    // store: bank bit on top, character slot below
    sssp_ram #(
        .WIDTH (8),
        .WORDS (2 ** AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (char_in),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign mem_wr_addr = {~play_bank_reg, load_count_reg[IW-1:0]};
    assign mem_rd_addr = {play_bank_next, read_index_next[IW-1:0]};

    // the saturated slot past the end reads as NUL
    assign index_in_range = read_index_reg < DEPTH_C;
    assign char_cur = !index_in_range ? sssp_pkg::CHAR_NUL :
                      byp_valid_reg   ? byp_data_reg : mem_rd_data;

    assign digit = (char_cur == sssp_pkg::CHAR_POINT) ? sssp_pkg::GLYPH_POINT
                                                      : char_cur - sssp_pkg::CHAR_ZERO;
    assign glyph_hit     = digit < sssp_pkg::GLYPH_COUNT;
    assign glyph_pattern = glyph_hit ? sssp_pkg::GLYPH_TABLE[digit[3:0]]
                                     : sssp_pkg::PATTERN_BLANK;

    assign load_count_inc = (load_count_reg < DEPTH_C) ? CW'(load_count_reg + 1'b1)
                                                        : load_count_reg;
    assign timeout_dec = (timeout_reg != 16'd0) ? 16'(timeout_reg - 1'b1) : 16'd0;

    // next state
    always_comb
    begin
        play_bank_next   = play_bank_reg;
        load_count_next  = load_count_reg;
        play_length_next = play_length_reg;
        read_index_next  = read_index_reg;
        phase_next       = phase_reg;
        timeout_next     = timeout_reg;
        last_glyph_next  = last_glyph_reg;
        mem_wr_en        = 1'b0;
        if (in_accept)
        begin
            unique case (sssp_pkg::action_t'(action))
                sssp_pkg::ACT_LOAD:
                begin
                    mem_wr_en = load_count_reg < DEPTH_C;
                    load_count_next = load_count_inc;
                    if (last_char)
                    begin
                        if (load_count_inc < DEPTH_C)
                        begin
                            play_bank_next   = ~play_bank_reg;
                            play_length_next = load_count_inc;
                            read_index_next  = '0;
                            phase_next       = sssp_pkg::PH_SENDING;
                        end
                        load_count_next = '0;
                    end
                end
                sssp_pkg::ACT_TICK:
                begin
                    timeout_next = timeout_dec;
                    unique case (phase_reg)
                        sssp_pkg::PH_SENDING:
                        begin
                            if (glyph_hit)
                            begin
                                last_glyph_next = digit[3:0];
                            end
                            if (index_in_range)
                            begin
                                read_index_next = CW'(read_index_reg + 1'b1);
                            end
                            timeout_next = on_ticks_reg;
                            phase_next   = sssp_pkg::PH_SHOWING;
                        end
                        sssp_pkg::PH_SHOWING:
                        begin
                            if (timeout_dec == 16'd0)
                            begin
                                timeout_next = off_ticks_reg;
                                phase_next   = sssp_pkg::PH_WAITING;
                            end
                        end
                        sssp_pkg::PH_WAITING:
                        begin
                            if (timeout_dec == 16'd0)
                            begin
                                if (read_index_reg < play_length_reg && index_in_range &&
                                    char_cur != sssp_pkg::CHAR_NUL)
                                begin
                                    phase_next = sssp_pkg::PH_SENDING;
                                end
                                else
                                begin
                                    read_index_next = '0;
                                    phase_next      = sssp_pkg::PH_IDLE;
                                end
                            end
                        end
                        sssp_pkg::PH_IDLE:
                        begin
                        end
                    endcase
                end
                sssp_pkg::ACT_RESEND:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // result of the accepted transaction
    always_comb
    begin
        sent_next    = 1'b0;
        pattern_next = 8'h00;
        unique case (sssp_pkg::action_t'(action))
            sssp_pkg::ACT_TICK:
            begin
                if (phase_reg == sssp_pkg::PH_SENDING)
                begin
                    sent_next    = 1'b1;
                    pattern_next = glyph_pattern;
                end
                else if (phase_reg == sssp_pkg::PH_SHOWING && timeout_dec == 16'd0)
                begin
                    sent_next    = 1'b1;
                    pattern_next = sssp_pkg::PATTERN_BLANK;
                end
            end
            sssp_pkg::ACT_RESEND:
            begin
                sent_next    = 1'b1;
                pattern_next = sssp_pkg::GLYPH_TABLE[last_glyph_reg];
            end
            sssp_pkg::ACT_LOAD:
            begin
            end
            default:
            begin
            end
        endcase
        out_valid_next = in_accept || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg    <= sssp_pkg::ON_TICKS_RESET;
            off_ticks_reg   <= sssp_pkg::OFF_TICKS_RESET;
            play_bank_reg   <= 1'b0;
            load_count_reg  <= '0;
            play_length_reg <= '0;
            read_index_reg  <= '0;
            phase_reg       <= sssp_pkg::PH_IDLE;
            timeout_reg     <= 16'd0;
            last_glyph_reg  <= 4'd0;
            byp_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sssp_pkg::CFG_ON_TICKS)
                begin
                    on_ticks_reg <= cfg_data;
                end
                else if (cfg_index == sssp_pkg::CFG_OFF_TICKS)
                begin
                    off_ticks_reg <= cfg_data;
                end
            end
            play_bank_reg   <= play_bank_next;
            load_count_reg  <= load_count_next;
            play_length_reg <= play_length_next;
            read_index_reg  <= read_index_next;
            phase_reg       <= phase_next;
            timeout_reg     <= timeout_next;
            last_glyph_reg  <= last_glyph_next;
            // ram read in the write cycle returns the old word
            byp_valid_reg   <= mem_wr_en && (mem_wr_addr == mem_rd_addr);
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= char_in;
        if (in_accept)
        begin
            sent_reg    <= sent_next;
            pattern_reg <= pattern_next;
            idle_reg    <= phase_next == sssp_pkg::PH_IDLE;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sent       = sent_reg;
    assign segments   = pattern_reg;
    assign spi_first  = pattern_reg[7];
    assign spi_second = {pattern_reg[6:0], 1'b0};
    assign idle       = idle_reg;

    `SSSP_ASSERT_ALWAYS(a_counts_bounded, load_count_reg <= DEPTH_C && play_length_reg < DEPTH_C, "load or play length out of range")
    `SSSP_ASSERT_ALWAYS(a_idle_matches, !out_valid_reg || (idle_reg == (phase_reg == sssp_pkg::PH_IDLE)), "idle flag disagrees with phase")
    `SSSP_ASSERT_ALWAYS(a_bypass_at_start, !byp_valid_reg || (phase_reg == sssp_pkg::PH_SENDING && read_index_reg == '0), "bypass outside string start")
    `SSSP_ASSERT_NEXT(a_send_shows, in_accept && action == sssp_pkg::ACT_TICK && phase_reg == sssp_pkg::PH_SENDING, out_valid_reg && sent_reg && phase_reg == sssp_pkg::PH_SHOWING, "send tick did not show a glyph")
    `SSSP_ASSERT_NEXT(a_last_clears, in_accept && action == sssp_pkg::ACT_LOAD && last_char, load_count_reg == '0, "load count not cleared after last character")

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

    import sssp_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASES       = 8;
    localparam int CYCLE_LIMIT  = 400000;

    // the unused action code, which the block must ignore
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // glyph 0 in the low byte
    localparam logic [127:0] SEG_FONT = {
        8'hA3, 8'hB0, 8'h06, 8'h9C, 8'hBF, 8'h7F, 8'h98, 8'h80,
        8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    typedef struct packed {
        logic       sent;
        logic [7:0] segments;
        logic       spi_first;
        logic [7:0] spi_second;
        logic       idle;
    } frame_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        logic        is_cfg;
        logic [15:0] on_val;
        logic [15:0] off_val;
        item_t       item;
        logic        typed;
        frame_t      want;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [7:0]  char_in;
    logic        last_char;
    logic        out_valid;
    logic        out_ready;
    logic        sent;
    logic [7:0]  segments;
    logic        spi_first;
    logic [7:0]  spi_second;
    logic        idle;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // player model state
    logic [7:0]  glyph_ram [2][DEPTH];
    logic        live_bank;
    int          fill_count;
    int          show_len;
    int          show_pos;
    phase_t      seq_phase;
    logic [15:0] dwell;
    logic [3:0]  recent_glyph;
    logic [15:0] lit_ticks;
    logic [15:0] dark_ticks;

    frame_t frames_due[$];
    step_t  script[$];

    int gap_max;
    int stall_max;
    int hold_off;
    int errors;
    int cycles;
    int items_sent;
    int frames_checked;
    int strings_taken;
    int strings_dropped;
    int patterns_out;

    seven_segment_sequence_player #(.DEPTH(DEPTH)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .char_in(char_in),
        .last_char(last_char),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sent(sent),
        .segments(segments),
        .spi_first(spi_first),
        .spi_second(spi_second),
        .idle(idle),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycles, frames_due.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic frame_t shown(logic [7:0] pattern);
        frame_t f;
        f.sent       = 1'b1;
        f.segments   = pattern;
        f.spi_first  = pattern[7];
        f.spi_second = {pattern[6:0], 1'b0};
        f.idle       = 1'b0;
        return f;
    endfunction

    // one step of the player: updates the model state, returns the frame it shifts out
    function automatic frame_t advance_player(item_t it);
        frame_t     f;
        logic       stage;
        logic [7:0] c;
        logic [7:0] d;
        f = '0;
        case (it.action)
            ACT_LOAD:
            begin
                stage = ~live_bank;
                if (fill_count < DEPTH)
                begin
                    glyph_ram[stage][fill_count] = it.ch;
                    fill_count++;
                end
                if (it.last)
                begin
                    if (fill_count < DEPTH)
                    begin
                        live_bank = stage;
                        show_len  = fill_count;
                        show_pos  = 0;
                        seq_phase = PH_SENDING;
                        strings_taken++;
                    end
                    else
                    begin
                        strings_dropped++;
                    end
                    fill_count = 0;
                end
            end
            ACT_TICK:
            begin
                if (dwell != 0)
                    dwell--;
                case (seq_phase)
                    PH_SENDING:
                    begin
                        c = glyph_ram[live_bank][show_pos];
                        d = (c == CHAR_POINT) ? GLYPH_POINT : c - CHAR_ZERO;
                        if (d < GLYPH_COUNT)
                        begin
                            recent_glyph = d[3:0];
                            f = shown(SEG_FONT[d[3:0] * 8 +: 8]);
                        end
                        else
                        begin
                            f = shown(PATTERN_BLANK);
                        end
                        if (show_pos < DEPTH)
                            show_pos++;
                        dwell     = lit_ticks;
                        seq_phase = PH_SHOWING;
                    end
                    PH_SHOWING:
                    begin
                        if (dwell == 0)
                        begin
                            f         = shown(PATTERN_BLANK);
                            dwell     = dark_ticks;
                            seq_phase = PH_WAITING;
                        end
                    end
                    PH_WAITING:
                    begin
                        if (dwell == 0)
                        begin
                            // a nul inside the string ends playback early
                            if (show_pos < show_len && show_pos < DEPTH &&
                                glyph_ram[live_bank][show_pos] != CHAR_NUL)
                            begin
                                seq_phase = PH_SENDING;
                            end
                            else
                            begin
                                show_pos  = 0;
                                seq_phase = PH_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ACT_RESEND:
            begin
                f = shown(SEG_FONT[recent_glyph * 8 +: 8]);
            end
            default:
            begin
            end
        endcase
        f.idle = (seq_phase == PH_IDLE);
        if (f.sent)
            patterns_out++;
        return f;
    endfunction

    function automatic step_t item_row(logic [1:0] a, logic [7:0] c, logic l);
        step_t s;
        s      = '0;
        s.item = {a, c, l};
        return s;
    endfunction

    function automatic step_t known_row(logic [1:0] a, logic [7:0] c, logic l, frame_t w);
        step_t s;
        s       = item_row(a, c, l);
        s.typed = 1'b1;
        s.want  = w;
        return s;
    endfunction

    function automatic step_t timing_row(logic [15:0] on_val, logic [15:0] off_val);
        step_t s;
        s         = '0;
        s.is_cfg  = 1'b1;
        s.on_val  = on_val;
        s.off_val = off_val;
        return s;
    endfunction

    task automatic flag(string what, int got, int want);
        errors++;
        $display("mismatch at result %0d: %s got %0h want %0h",
                 frames_checked, what, got, want);
    endtask

    task automatic compare_frame();
        frame_t want;
        if (frames_due.size() == 0)
        begin
            flag("result with nothing pending, segments", segments, 0);
        end
        else
        begin
            want = frames_due.pop_front();
            if (sent !== want.sent)
                flag("sent", sent, want.sent);
            if (segments !== want.segments)
                flag("segments", segments, want.segments);
            if (spi_first !== want.spi_first)
                flag("spi_first", spi_first, want.spi_first);
            if (spi_second !== want.spi_second)
                flag("spi_second", spi_second, want.spi_second);
            if (idle !== want.idle)
                flag("idle", idle, want.idle);
        end
        frames_checked++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            compare_frame();
    end

    // result side: random stall before each transaction, or a requested long hold
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off > 0)
            begin
                n        = hold_off;
                hold_off = 0;
            end
            else
            begin
                n = $urandom_range(0, stall_max);
            end
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic drive_item(item_t it, logic known, frame_t want);
        int     gap;
        frame_t f;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= it.action;
        char_in   <= it.ch;
        last_char <= it.last;
        do @(posedge clk); while (!in_ready);
        f = advance_player(it);
        frames_due.push_back(known ? want : f);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (frames_due.size() != 0);
    endtask

    task automatic set_timing(logic [15:0] on_val, logic [15:0] off_val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ON_TICKS;
        cfg_data  <= on_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_OFF_TICKS;
        cfg_data  <= off_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        lit_ticks  = on_val;
        dark_ticks = off_val;
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 15))
            0:       return CHAR_NUL;
            1:       return CHAR_POINT;
            2, 3:    return 8'($urandom_range(0, 255));
            // just outside the digit range
            4:       return $urandom_range(0, 1) ? CHAR_ZERO - 8'd1 : CHAR_ZERO + 8'd16;
            default: return CHAR_ZERO + 8'($urandom_range(0, 15));
        endcase
    endfunction

    task automatic tick_or_noise();
        int         r;
        logic [1:0] a;
        r = $urandom_range(0, 31);
        a = (r < 3) ? ACT_RESEND : (r == 3) ? ACT_SPARE : ACT_TICK;
        drive_item({a, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))}, 1'b0, '0);
    endtask

    // load one string, sometimes over the limit, then drive at most 48 tick or noise items for its playback
    task automatic play_string();
        int len;
        int span;
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(DEPTH, DEPTH + 3);
        else
            len = $urandom_range(1, DEPTH - 1);
        for (int i = 0; i < len; i++)
        begin
            drive_item({ACT_LOAD, pick_char(), 1'(i == len - 1)}, 1'b0, '0);
            // ticks between loads keep the previous string playing
            if ($urandom_range(0, 3) == 0)
                tick_or_noise();
        end
        span = len * (int'(lit_ticks) + int'(dark_ticks) + 3) + $urandom_range(0, 4);
        if (span > 48)
            span = 48;
        repeat (span) tick_or_noise();
    endtask

    initial
    begin
        int          stop_at;
        logic [15:0] on_val;
        logic [15:0] off_val;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_LOAD;
        char_in   = 8'd0;
        last_char = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ON_TICKS;
        cfg_data  = 16'd0;

        live_bank       = 1'b0;
        fill_count      = 0;
        show_len        = 0;
        show_pos        = 0;
        seq_phase       = PH_IDLE;
        dwell           = 16'd0;
        recent_glyph    = 4'd0;
        lit_ticks       = ON_TICKS_RESET;
        dark_ticks      = OFF_TICKS_RESET;
        gap_max         = 9;
        stall_max       = 9;
        hold_off        = 0;
        errors          = 0;
        cycles          = 0;
        items_sent      = 0;
        frames_checked  = 0;
        strings_taken   = 0;
        strings_dropped = 0;
        patterns_out    = 0;

        script = '{
            known_row(ACT_RESEND, 8'h00, 1'b0, {1'b1, 8'hC0, 1'b1, 8'h80, 1'b1}),
            known_row(ACT_TICK, 8'h00, 1'b0, {1'b0, 8'h00, 1'b0, 8'h00, 1'b1}),
            known_row(ACT_SPARE, 8'hFF, 1'b1, {1'b0, 8'h00, 1'b0, 8'h00, 1'b1}),
            known_row(ACT_LOAD, CHAR_POINT, 1'b0, {1'b0, 8'h00, 1'b0, 8'h00, 1'b1}),
            known_row(ACT_LOAD, 8'hFF, 1'b1, {1'b0, 8'h00, 1'b0, 8'h00, 1'b0}),
            known_row(ACT_TICK, 8'h00, 1'b0, {1'b1, 8'h7F, 1'b0, 8'hFE, 1'b0}),
            known_row(ACT_RESEND, 8'h00, 1'b0, {1'b1, 8'h7F, 1'b0, 8'hFE, 1'b0}),
            timing_row(16'd0, 16'd0),
            // nul first shows blank, nul later ends the string
            item_row(ACT_LOAD, CHAR_NUL, 1'b0),
            item_row(ACT_LOAD, CHAR_ZERO + 8'd15, 1'b0),
            item_row(ACT_LOAD, CHAR_NUL, 1'b1),
            known_row(ACT_TICK, 8'h00, 1'b0, {1'b1, 8'hFF, 1'b1, 8'hFE, 1'b0}),
            item_row(ACT_TICK, 8'h00, 1'b0),
            item_row(ACT_TICK, 8'h00, 1'b0),
            known_row(ACT_TICK, 8'h00, 1'b0, {1'b1, 8'hA3, 1'b1, 8'h46, 1'b0}),
            item_row(ACT_TICK, 8'h00, 1'b0),
            known_row(ACT_TICK, 8'h00, 1'b0, {1'b0, 8'h00, 1'b0, 8'h00, 1'b1}),
            known_row(ACT_RESEND, 8'h00, 1'b0, {1'b1, 8'hA3, 1'b1, 8'h46, 1'b1}),
            // a full-depth string is too long and gets dropped
            item_row(ACT_LOAD, CHAR_ZERO + 8'd16, 1'b0),
            item_row(ACT_LOAD, CHAR_ZERO - 8'd1, 1'b0),
            item_row(ACT_LOAD, CHAR_ZERO + 8'd1, 1'b0),
            item_row(ACT_LOAD, CHAR_ZERO + 8'd2, 1'b0),
            item_row(ACT_LOAD, CHAR_ZERO + 8'd3, 1'b0),
            item_row(ACT_LOAD, CHAR_ZERO + 8'd4, 1'b0),
            item_row(ACT_LOAD, CHAR_ZERO + 8'd5, 1'b0),
            item_row(ACT_LOAD, CHAR_ZERO + 8'd6, 1'b1),
            known_row(ACT_TICK, 8'h00, 1'b0, {1'b0, 8'h00, 1'b0, 8'h00, 1'b1})
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].is_cfg)
                set_timing(script[i].on_val, script[i].off_val);
            else
                drive_item(script[i].item, script[i].typed, script[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin on_val = 16'd0;     off_val = 16'd0;     end
                1:       begin on_val = 16'd1;     off_val = 16'd0;     end
                2:       begin on_val = 16'd0;     off_val = 16'd1;     end
                3:       begin on_val = 16'd2;     off_val = 16'd3;     end
                4:       begin on_val = 16'hFFFF;  off_val = 16'hFFFF;  end
                5:       begin on_val = 16'hFFFF;  off_val = 16'd0;     end
                6:       begin on_val = 16'd0;     off_val = 16'hFFFF;  end
                default: begin on_val = 16'd3;     off_val = 16'd1;     end
            endcase
            set_timing(on_val, off_val);
            gap_max   = (p == 1) ? 0 : 9;
            stall_max = (p == 1) ? 0 : 9;
            if (p == 2)
            begin
                // back-to-back input against a long output hold fills the block
                gap_max  = 0;
                hold_off = 70;
            end
            stop_at = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < stop_at)
            begin
                play_string();
                if ($urandom_range(0, 7) == 0)
                    drain();
            end
        end

        drain();
        repeat (4) @(posedge clk);

        $display("%0d transactions in, %0d results checked, %0d mismatches",
                 items_sent, frames_checked, errors);
        $display("%0d strings played, %0d overlong dropped, %0d patterns shifted out",
                 strings_taken, strings_dropped, patterns_out);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== seven_segment_sequence_player.f =====
+incdir+rtl/core
rtl/core/sssp_pkg.sv
rtl/core/sssp_ram.sv
rtl/core/seven_segment_sequence_player.sv
sim/tb_top.sv
